FILE: rtl/phfe_pkg.sv
// Shared constants, types and helper functions of the PPP async HDLC frame encoder.
package phfe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [7:0]  CTL_LIMIT = 8'h20;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCM   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APPEND = 1'd1;

  // Output slots of one item, in line order
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned SLOT_OPEN    = 0;
  localparam int unsigned SLOT_DATA_ES = 1;
  localparam int unsigned SLOT_DATA    = 2;
  localparam int unsigned SLOT_LO_ES   = 3;
  localparam int unsigned SLOT_LO      = 4;
  localparam int unsigned SLOT_HI_ES   = 5;
  localparam int unsigned SLOT_HI      = 6;
  localparam int unsigned SLOT_CLOSE   = 7;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // One expanded item: which slots go out, and the bytes of the variable slots
  typedef struct packed {
    slot_mask_t mask;
    logic [7:0] data_val;
    logic [7:0] lo_val;
    logic [7:0] hi_val;
  } item_t;

  // Add one byte to a reflected FCS-16
  function automatic logic [15:0] fcs_add(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] v;
    v = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ FCS_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  // Byte needs an escape prefix on the line
  function automatic logic needs_esc(input logic [7:0] b, input logic all_ctl,
                                     input logic [31:0] accm);
    logic is_ctl;
    is_ctl = (b < CTL_LIMIT);
    return (b == ESC_BYTE) || (b == FLAG_BYTE) || (is_ctl && (all_ctl || accm[b[4:0]]));
  endfunction

endpackage

FILE: rtl/phfe_emit.sv
// Slot buffer and output register: drains one expanded item, one line byte per cycle unless stalled.
module phfe_emit import phfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  item_t      item_i,
  output logic       load_rdy_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // out_byte
  output logic       m_axis_tlast_o,   // run_last
  output logic [0:0] m_axis_tuser_o    // [0] frame_done
);

  slot_mask_t pend_q, pend_d;
  logic [7:0] data_q, lo_q, hi_q;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_done_q, out_done_d;

  slot_mask_t pick, rest;
  logic       adv, busy;

  assign adv  = !out_vld_q || m_axis_tready_i;
  assign busy = (pend_q != '0);
  // Isolate the lowest pending slot
  assign pick = pend_q & (~pend_q + slot_mask_t'(1));
  assign rest = pend_q & ~pick;

  assign load_rdy_o = !busy || (adv && (rest == '0));

  always_comb begin
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    if (adv) begin
      pend_d     = rest;
      out_vld_d  = busy;
      out_last_d = (rest == '0);
      out_done_d = pick[SLOT_CLOSE];
      out_byte_d = ({8{pick[SLOT_OPEN] | pick[SLOT_CLOSE]}} & FLAG_BYTE)
                 | ({8{pick[SLOT_DATA_ES] | pick[SLOT_LO_ES] | pick[SLOT_HI_ES]}} & ESC_BYTE)
                 | ({8{pick[SLOT_DATA]}} & data_q)
                 | ({8{pick[SLOT_LO]}} & lo_q)
                 | ({8{pick[SLOT_HI]}} & hi_q);
    end
    if (load_i && load_rdy_o) begin
      pend_d = item_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
    if (load_i && load_rdy_o) begin
      data_q <= item_i.data_val;
      lo_q   <= item_i.lo_val;
      hi_q   <= item_i.hi_val;
    end
  end

  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tdata_o    = out_byte_q;
  assign m_axis_tlast_o    = out_last_q;
  assign m_axis_tuser_o[0] = out_done_q;

`ifndef SYNTH
  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && load_rdy_o |=> pend_q != '0)
    else $error("loaded item left no pending slot");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i && busy |=> $stable(pend_q))
    else $error("pending slots moved during output stall");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_done_q |-> out_last_q && (out_byte_q == FLAG_BYTE))
    else $error("closing flag not last byte of its run");
`endif

endmodule

FILE: rtl/ppp_async_hdlc_frame_encoder.sv
// Top level of the PPP async HDLC frame encoder (byte stuffing plus FCS-16).
//
// Each accepted input transfer carries one raw frame byte and produces one to
// eight line bytes on the output stream, one byte per cycle unless the output
// stalls: an opening flag when the byte opens a frame, the byte itself
// (escaped as 0x7D, byte^0x20 when needed), and, when it ends the frame, the
// complemented FCS-16 low byte first (escaped the same way, omitted when
// append_fcs is 0) and a closing flag. An item occupies the slot buffer until
// its last line byte leaves it; the slot buffer drains one byte per cycle into
// the output register unless the output stalls, and the next item is taken in
// the same cycle its predecessor's last byte leaves the buffer. The FCS is
// folded in at acceptance and the bytes are expanded into the slot buffer in
// that same cycle. tlast marks the last line byte caused by an input transfer;
// tuser[0] marks the closing flag. Write configuration only while the block
// is idle.
module ppp_async_hdlc_frame_encoder import phfe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  // Input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,  // data_byte
  input  logic                 s_axis_tlast_i,  // last_of_frame
  input  logic [1:0]           s_axis_tuser_i,  // [0] first_of_frame, [1] escape_all_controls
  // Output stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,  // out_byte
  output logic                 m_axis_tlast_o,  // run_last
  output logic [0:0]           m_axis_tuser_o   // [0] frame_done
);

  logic [31:0] accm_q;
  logic        app_q;
  logic [15:0] fcs_q, fcs_d;

  logic        s_acc;
  logic        first, all_ctl, use_fcs;
  logic [15:0] fcs_base, fcs_new, fcs_tx;
  logic        esc_d, esc_lo, esc_hi;
  item_t       item;

  assign first   = s_axis_tuser_i[0];
  assign all_ctl = s_axis_tuser_i[1];
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accm_q <= 32'hFFFF_FFFF;
      app_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACCM:   accm_q <= cfg_data_i;
        REG_APPEND: app_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Running FCS: restart on a first mark, fold in the byte, reset after closing
  assign fcs_base = first ? FCS_INIT : fcs_q;
  assign fcs_new  = fcs_add(fcs_base, s_axis_tdata_i);
  assign fcs_tx   = ~fcs_new;
  assign fcs_d    = s_axis_tlast_i ? FCS_INIT : fcs_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_q <= FCS_INIT;
    end else if (s_acc) begin
      fcs_q <= fcs_d;
    end
  end

  // Expand the item into line slots
  assign use_fcs = s_axis_tlast_i && app_q;
  assign esc_d   = needs_esc(s_axis_tdata_i, all_ctl, accm_q);
  assign esc_lo  = needs_esc(fcs_tx[7:0], all_ctl, accm_q);
  assign esc_hi  = needs_esc(fcs_tx[15:8], all_ctl, accm_q);

  always_comb begin
    item.mask               = '0;
    item.mask[SLOT_OPEN]    = first;
    item.mask[SLOT_DATA_ES] = esc_d;
    item.mask[SLOT_DATA]    = 1'b1;
    item.mask[SLOT_LO_ES]   = use_fcs && esc_lo;
    item.mask[SLOT_LO]      = use_fcs;
    item.mask[SLOT_HI_ES]   = use_fcs && esc_hi;
    item.mask[SLOT_HI]      = use_fcs;
    item.mask[SLOT_CLOSE]   = s_axis_tlast_i;
    item.data_val = esc_d  ? (s_axis_tdata_i ^ ESC_XOR) : s_axis_tdata_i;
    item.lo_val   = esc_lo ? (fcs_tx[7:0] ^ ESC_XOR)    : fcs_tx[7:0];
    item.hi_val   = esc_hi ? (fcs_tx[15:8] ^ ESC_XOR)   : fcs_tx[15:8];
  end

  phfe_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (s_axis_tvalid_i),
    .item_i          (item),
    .load_rdy_o      (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

`ifndef SYNTH
  a_fcs_reset_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast_i |=> fcs_q == FCS_INIT)
    else $error("FCS not restarted after closing flag");

  a_fcs_restart_on_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && first && !s_axis_tlast_i |=>
      fcs_q == fcs_add(FCS_INIT, $past(s_axis_tdata_i)))
    else $error("FCS not restarted on opening byte");

  a_fcs_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_acc |=> $stable(fcs_q))
    else $error("FCS changed without an input transfer");
`endif

endmodule
